/* rtl/core/mfr_pkg.sv */
package mfr_pkg;

    // Frame buffer depth; lengths are clamped to it and it bounds the byte count.
    localparam int unsigned BUFFER_DEPTH = 64;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned POS_W   = 6;

    // Length field mask, checksum scramble and self-check constants.
    localparam logic [7:0] LEN_MASK = 8'b0001_1111;
    localparam logic [7:0] SUM_XOR  = 8'hAA;
    localparam logic [2:0] CHK_BASE = 3'b100;
    localparam logic [2:0] CHK_LOW  = 3'b111;

    localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(BUFFER_DEPTH);

    // Configuration register indices.
    localparam logic [1:0] CFG_STATION_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_EXT_COMMAND_A   = 2'd1;
    localparam logic [1:0] CFG_EXT_COMMAND_B   = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] station_address;
        logic [CHAR_W-1:0] ext_command_a;
        logic [CHAR_W-1:0] ext_command_b;
    } mfr_cfg_t;

    typedef struct packed {
        logic               stored;
        logic [POS_W-1:0]   position;
        logic [CHAR_W-1:0]  frame_byte;
        logic               receiving;
        logic               frame_done;
        logic               frame_error;
        logic               extended;
        logic [COUNT_W-1:0] frame_length;
        logic               checksum_ok;
    } mfr_result_t;

    // Self-check of a length byte: the top three bits must equal the low
    // three bits of the length XOR (4 | length >> 3).
    function automatic logic length_check_ok(input logic [CHAR_W-1:0] v);
        logic [2:0] a;
        logic [2:0] b;
        begin
            a = v[2:0] & CHK_LOW;
            b = CHK_BASE | {1'b0, v[4:3]};
            length_check_ok = (v[7:5] == (a ^ b));
        end
    endfunction

    // Clamp a length to the buffer depth.
    function automatic logic [COUNT_W-1:0] clamp_len(input logic [COUNT_W-1:0] v);
        begin
            clamp_len = (v > DEPTH_COUNT) ? DEPTH_COUNT : v;
        end
    endfunction

endpackage

/* rtl/core/mfr_if.sv */
// Character channel: one nine-bit serial character per request.
interface mfr_char_if
    import mfr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_char;
    logic              address_bit;

    modport source (output valid, output rx_char, output address_bit, input ready);
    modport sink   (input valid, input rx_char, input address_bit, output ready);
endinterface

// Result channel: one result per character.
interface mfr_result_if
    import mfr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               stored;
    logic [POS_W-1:0]   position;
    logic [CHAR_W-1:0]  frame_byte;
    logic               receiving;
    logic               frame_done;
    logic               frame_error;
    logic               extended;
    logic [COUNT_W-1:0] frame_length;
    logic               checksum_ok;

    modport source (
        output valid, output stored, output position, output frame_byte,
        output receiving, output frame_done, output frame_error, output extended,
        output frame_length, output checksum_ok, input ready
    );
    modport sink (
        input valid, input stored, input position, input frame_byte,
        input receiving, input frame_done, input frame_error, input extended,
        input frame_length, input checksum_ok, output ready
    );
endinterface

/* rtl/core/mfr_frame_ctrl.sv */
module mfr_frame_ctrl
    import mfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [CHAR_W-1:0] rx_char,
    input  logic              address_bit,
    input  mfr_cfg_t          cfg,
    output mfr_result_t       result
);

    logic               hunting_reg, hunting_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0] length_target_reg, length_target_next;
    logic [CHAR_W-1:0]  command_byte_reg, command_byte_next;
    logic [CHAR_W-1:0]  running_sum_reg, running_sum_next;
    logic               extension_flag_reg, extension_flag_next;

    logic               addr_match;
    logic [CHAR_W-1:0]  sum_term;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] ext_sum;
    logic               len_ok;
    logic               ext_cmd;
    logic               abort;

    // Per-character terms shared by the frame update.
    assign addr_match = address_bit && (rx_char == cfg.station_address);
    assign sum_term   = (rx_char + CHAR_W'(byte_count_reg)) ^ SUM_XOR;
    assign count_inc  = byte_count_reg + COUNT_W'(1);
    assign ext_sum    = length_target_reg + COUNT_W'(rx_char & LEN_MASK);
    assign len_ok     = length_check_ok(rx_char);
    assign ext_cmd    = (command_byte_reg == cfg.ext_command_a) ||
                        (command_byte_reg == cfg.ext_command_b);

    // Next frame state and the result for the current character.
    always_comb
    begin
        hunting_next        = hunting_reg;
        byte_count_next     = byte_count_reg;
        length_target_next  = length_target_reg;
        command_byte_next   = command_byte_reg;
        running_sum_next    = running_sum_reg;
        extension_flag_next = extension_flag_reg;
        abort               = 1'b0;
        result              = '0;

        if (hunting_reg)
        begin
            if (addr_match)
            begin
                hunting_next        = 1'b0;
                byte_count_next     = COUNT_W'(1);
                length_target_next  = '0;
                extension_flag_next = 1'b0;
                running_sum_next    = rx_char ^ SUM_XOR;
                result.stored       = 1'b1;
                result.frame_byte   = rx_char;
            end
            result.extended = extension_flag_next;
        end
        else if (byte_count_reg < DEPTH_COUNT)
        begin
            result.stored     = 1'b1;
            result.position   = POS_W'(byte_count_reg);
            result.frame_byte = rx_char;
            running_sum_next  = running_sum_reg + sum_term;
            byte_count_next   = count_inc;
            if (byte_count_reg == COUNT_W'(2))
            begin
                command_byte_next = rx_char;
            end

            // Length byte, then the optional extension length.
            if (count_inc == COUNT_W'(2))
            begin
                if (len_ok)
                begin
                    length_target_next = clamp_len(COUNT_W'(rx_char & LEN_MASK));
                end
                else
                begin
                    abort = 1'b1;
                end
            end
            else if (count_inc == COUNT_W'(4) && ext_cmd)
            begin
                if (len_ok)
                begin
                    extension_flag_next = 1'b1;
                    length_target_next  = clamp_len(ext_sum);
                end
                else
                begin
                    abort = 1'b1;
                end
            end

            result.extended = extension_flag_next;
            if (abort)
            begin
                result.frame_error  = 1'b1;
                hunting_next        = 1'b1;
                extension_flag_next = 1'b0;
            end
            else if (count_inc >= length_target_next)
            begin
                result.frame_done   = 1'b1;
                result.checksum_ok  = (rx_char == running_sum_reg);
                hunting_next        = 1'b1;
                extension_flag_next = 1'b0;
            end
        end
        else
        begin
            // Overflow: the buffer is full, the character is dropped.
            result.extended     = extension_flag_reg;
            result.frame_error  = 1'b1;
            hunting_next        = 1'b1;
            extension_flag_next = 1'b0;
        end

        result.receiving    = !hunting_next;
        result.frame_length = length_target_next;
    end

    // Frame state registers, updated on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg        <= 1'b1;
            byte_count_reg     <= '0;
            length_target_reg  <= '0;
            command_byte_reg   <= '0;
            running_sum_reg    <= '0;
            extension_flag_reg <= 1'b0;
        end
        else if (take)
        begin
            hunting_reg        <= hunting_next;
            byte_count_reg     <= byte_count_next;
            length_target_reg  <= length_target_next;
            command_byte_reg   <= command_byte_next;
            running_sum_reg    <= running_sum_next;
            extension_flag_reg <= extension_flag_next;
        end
    end

    // The byte count never passes the buffer depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= DEPTH_COUNT)
        else $error("byte count beyond buffer depth");

    // An open frame always holds at least its address byte.
    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        !hunting_reg |-> byte_count_reg != '0)
        else $error("open frame with zero byte count");

    // Completion or abort returns the receiver to address hunting.
    a_close_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        take && (result.frame_done || result.frame_error) |=> hunting_reg)
        else $error("frame closed but not hunting");

    // The extension flag is only ever set inside an open frame.
    a_ext_open: assert property (@(posedge clk) disable iff (!rst_n)
        extension_flag_reg |-> !hunting_reg)
        else $error("extension flag set while hunting");

endmodule

/* rtl/core/mfr_out_reg.sv */
module mfr_out_reg
    import mfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_valid,
    output logic        load_ready,
    input  mfr_result_t load_result,
    mfr_result_if.source results
);

    logic        valid_reg;
    mfr_result_t result_reg;

    // A new result may enter whenever the register is empty or being drained.
    assign load_ready = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= load_valid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            result_reg <= load_result;
        end
    end

    assign results.valid        = valid_reg;
    assign results.stored       = result_reg.stored;
    assign results.position     = result_reg.position;
    assign results.frame_byte   = result_reg.frame_byte;
    assign results.receiving    = result_reg.receiving;
    assign results.frame_done   = result_reg.frame_done;
    assign results.frame_error  = result_reg.frame_error;
    assign results.extended     = result_reg.extended;
    assign results.frame_length = result_reg.frame_length;
    assign results.checksum_ok  = result_reg.checksum_ok;

    // A loaded result is presented on the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_valid && load_ready |=> valid_reg)
        else $error("loaded result not presented");

    // Done and error never come together.
    a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(result_reg.frame_done && result_reg.frame_error))
        else $error("frame both done and aborted");

    // A checksum pass is only reported with a completed frame.
    a_ck_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && result_reg.checksum_ok |-> result_reg.frame_done)
        else $error("checksum flag without frame completion");

endmodule

/* rtl/core/multidrop_frame_receiver_unit.sv */
// A result is registered and presented in the cycle after its character request is taken.
// Throughput: one character per cycle while results are taken; the frame state updates in a single pass
// and the result register is reloaded whenever it is empty or being taken.
// Reset (rst_n, asynchronous, active low) returns the receiver to address hunting,
// clears all frame state and the configuration registers, and empties the output.
module multidrop_frame_receiver_unit
    import mfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CHAR_W-1:0] cfg_data,
    mfr_char_if.sink          chars,
    mfr_result_if.source      results
);

    mfr_cfg_t    cfg_reg;
    mfr_result_t frame_result;
    logic        load_ready;
    logic        take;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STATION_ADDRESS: cfg_reg.station_address <= cfg_data;
                CFG_EXT_COMMAND_A:   cfg_reg.ext_command_a   <= cfg_data;
                CFG_EXT_COMMAND_B:   cfg_reg.ext_command_b   <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign chars.ready = load_ready;
    assign take        = chars.valid && load_ready;

    mfr_frame_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .rx_char     (chars.rx_char),
        .address_bit (chars.address_bit),
        .cfg         (cfg_reg),
        .result      (frame_result)
    );

    mfr_out_reg u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (chars.valid),
        .load_ready  (load_ready),
        .load_result (frame_result),
        .results     (results)
    );

endmodule
